// ----- hw/rtl/slipo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slipo_pkg: shared types and constants of the sorted insertion list
// Opcodes, command and result beats, back-end states and queue sizing.
// ----------------------------------------------------------------------------
package slipo_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VALUE_W      = 32;
  localparam int OPCODE_W     = 2;
  localparam int ENTRY_CNT_W  = 6;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PURGE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DUMP   = 2'd2;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_PURGE,
    CMD_DUMP,
    CMD_STATUS
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PURGE,
    ST_DUMP
  } back_state_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  entry_value;
    logic [ENTRY_CNT_W-1:0]     entry_count;
    logic                       is_last;
    logic                       list_empty;
    logic                       dropped_full;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_list_insert_purge_odd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_purge_odd_core: bounded sorted list of signed values
// Keeps up to CAPACITY signed 32-bit entries in ascending order.
// ----------------------------------------------------------------------------
// Usage:
// The input side is a queue: drive in_opcode and in_value with in_push high;
// the beat is taken on an edge where in_full is low. Opcode insert places the
// value ahead of the first entry greater than or equal to it, purge removes
// every odd entry, dump streams all entries in ascending order. Each command
// produces one status beat, except a dump of a non-empty list, which gives
// one beat per entry with out_is_last on the final one.
// The result side is a queue too: a beat is on the out_ ports while out_empty
// is low and leaves on an edge where out_pop is high.
// With nothing queued ahead, an insert, status or empty-dump result is pushed
// into the result queue as the back end takes the command, a dump's entries
// follow from ST_DUMP, and a purge status follows the sweep over held entries.
// Inserts and status commands run at one per cycle through the
// compare-and-shift cells while the result queue is not full. A purge holds
// the back-end sequencer for its whole sweep; a dump holds it to its last entry.
// Reset (rst_n low, synchronous) empties the list and both queues. When the
// receiver stops popping, the result queue fills, the back end holds, and the
// command queue then raises in_full.
// ----------------------------------------------------------------------------
module sorted_list_insert_purge_odd_core
  import slipo_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [OPCODE_W-1:0]       in_opcode,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic signed [VALUE_W-1:0] out_entry_value,
  output logic [ENTRY_CNT_W-1:0]    out_entry_count,
  output logic                      out_is_last,
  output logic                      out_list_empty,
  output logic                      out_dropped_full
);

  // Commands cross from the front end to the back end through a short queue.
  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_take;

  // Results leave the back end into a second short queue that decouples the
  // list logic from a stalling receiver.
  logic    res_full;
  logic    res_push;
  result_t res;
  logic [$bits(result_t)-1:0] res_bits;
  result_t out_res;

  slipo_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .cmd_take  (cmd_take),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  slipo_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  slipo_fifo #(
    .W ($bits(result_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_bits)
  );

  assign out_res          = result_t'(res_bits);
  assign out_entry_value  = out_res.entry_value;
  assign out_entry_count  = out_res.entry_count;
  assign out_is_last      = out_res.is_last;
  assign out_list_empty   = out_res.list_empty;
  assign out_dropped_full = out_res.dropped_full;

endmodule

`default_nettype wire

// ----- hw/rtl/slipo_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slipo_fifo: short queue
// Two-entry first-in first-out buffer used between the front and back ends
// and on the result side.
// ----------------------------------------------------------------------------
module slipo_fifo
  import slipo_pkg::*;
#(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  logic [W-1:0]      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/slipo_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slipo_front: input front end
// Accepts input beats, classifies the opcode and queues commands.
// ----------------------------------------------------------------------------
module slipo_front
  import slipo_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [OPCODE_W-1:0]       in_opcode,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      cmd_take,
  output logic                      cmd_valid,
  output cmd_t                      cmd
);

  cmd_t                cmd_in;
  logic                cmd_empty;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  // Unused opcodes are carried as a plain status request.
  always_comb begin
    cmd_in.value = in_value;
    case (in_opcode)
      OP_INSERT: cmd_in.kind = CMD_INSERT;
      OP_PURGE:  cmd_in.kind = CMD_PURGE;
      OP_DUMP:   cmd_in.kind = CMD_DUMP;
      default:   cmd_in.kind = CMD_STATUS;
    endcase
  end

  slipo_fifo #(
    .W ($bits(cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .din   (cmd_in),
    .pop   (cmd_take),
    .empty (cmd_empty),
    .dout  (cmd_bits)
  );

  assign cmd_valid = !cmd_empty;
  assign cmd       = cmd_t'(cmd_bits);

endmodule

`default_nettype wire

// ----- hw/rtl/slipo_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slipo_back: list back end
// Compare-and-shift cells holding the sorted list, plus the sequencer that
// runs purge sweeps and dumps.
// ----------------------------------------------------------------------------
module slipo_back
  import slipo_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_take,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  localparam int CW = $clog2(CAPACITY);
  localparam int NW = $clog2(CAPACITY + 1);
  localparam logic [NW-1:0] CAP_N = NW'(CAPACITY);

  logic signed [VALUE_W-1:0] cell_r   [CAPACITY];
  logic signed [VALUE_W-1:0] cell_nxt [CAPACITY];
  logic [CAPACITY-1:0]       take;
  logic [NW-1:0]             count_r;
  logic [NW-1:0]             count_nxt;
  logic [NW-1:0]             ptr_r;
  logic [NW-1:0]             ptr_nxt;
  back_state_t               state_r;
  back_state_t               state_nxt;
  logic                      do_ins;
  logic                      do_del;
  logic                      list_full;
  logic                      ptr_live;
  logic                      at_last;
  logic signed [VALUE_W-1:0] rd_data;

  assign list_full = count_r == CAP_N;
  assign ptr_live  = ptr_r < count_r;
  assign at_last   = (ptr_r + NW'(1)) == count_r;
  assign rd_data   = cell_r[ptr_r[CW-1:0]];

  // A cell takes part in an insert when it is empty or holds a value not
  // below the new one; the first such cell receives the new value.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      take[i] = (NW'(i) >= count_r) || (cmd.value <= cell_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_ins && take[i]) begin
        if (i == 0 || !take[(i > 0) ? i - 1 : 0]) begin
          cell_nxt[i] = cmd.value;
        end else begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del && NW'(i) >= ptr_r) begin
        cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_PURGE) begin
          state_nxt = ST_PURGE;
        end else if (cmd_valid && cmd.kind == CMD_DUMP && count_r != '0) begin
          state_nxt = ST_DUMP;
        end
      end
      ST_PURGE: begin
        if (!ptr_live && !res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (!res_full && at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take      = 1'b0;
    res_push      = 1'b0;
    do_ins        = 1'b0;
    do_del        = 1'b0;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    res           = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_INSERT: begin
              if (!res_full) begin
                cmd_take         = 1'b1;
                res_push         = 1'b1;
                do_ins           = !list_full;
                count_nxt        = list_full ? count_r : count_r + NW'(1);
                res.is_last      = 1'b1;
                res.dropped_full = list_full;
              end
            end
            CMD_PURGE: begin
              cmd_take = 1'b1;
              ptr_nxt  = '0;
            end
            CMD_DUMP: begin
              if (count_r == '0) begin
                if (!res_full) begin
                  cmd_take       = 1'b1;
                  res_push       = 1'b1;
                  res.is_last    = 1'b1;
                  res.list_empty = 1'b1;
                end
              end else begin
                cmd_take = 1'b1;
                ptr_nxt  = '0;
              end
            end
            default: begin
              if (!res_full) begin
                cmd_take    = 1'b1;
                res_push    = 1'b1;
                res.is_last = 1'b1;
              end
            end
          endcase
        end
      end
      ST_PURGE: begin
        if (ptr_live) begin
          if (rd_data[0]) begin
            do_del    = 1'b1;
            count_nxt = count_r - NW'(1);
          end else begin
            ptr_nxt = ptr_r + NW'(1);
          end
        end else if (!res_full) begin
          res_push    = 1'b1;
          res.is_last = 1'b1;
        end
      end
      ST_DUMP: begin
        if (!res_full) begin
          res_push        = 1'b1;
          res.entry_value = rd_data;
          res.is_last     = at_last;
          ptr_nxt         = ptr_r + NW'(1);
        end
      end
      default: begin
      end
    endcase
    res.entry_count = ENTRY_CNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/slipo_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slipo_checker: port-level checks of the sorted list core
// Watches the result queue and the reset behavior of the top level.
// ----------------------------------------------------------------------------
module slipo_checker
  import slipo_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_full,
  input logic                      out_empty,
  input logic                      out_pop,
  input logic signed [VALUE_W-1:0] out_entry_value,
  input logic [ENTRY_CNT_W-1:0]    out_entry_count,
  input logic                      out_is_last,
  input logic                      out_list_empty,
  input logic                      out_dropped_full
);

  // Reset leaves both queues empty.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting result beat stays put until popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_entry_value)
      && $stable(out_entry_count) && $stable(out_is_last))
    else $error("result beat changed while stalled");

  // An empty dump is a single closing beat with nothing held.
  a_empty_dump: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_list_empty |-> out_is_last && out_entry_count == '0
      && out_entry_value == '0 && !out_dropped_full)
    else $error("malformed empty-dump beat");

  // A refused insert is a closing status beat.
  a_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_dropped_full |-> out_is_last && out_entry_value == '0)
    else $error("malformed dropped-insert beat");

  // A beat that is not the last of its command carries no status flag.
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_is_last |-> !out_list_empty && !out_dropped_full)
    else $error("status flag on a non-final beat");

endmodule

bind sorted_list_insert_purge_odd_core slipo_checker u_slipo_checker (.*);

`default_nettype wire
